[src/rorb_pkg.sv]
`timescale 1ns / 1ps

package rorb_pkg;

  localparam int REORDER_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF      = 16;

  localparam int PROTO_W = 32;
  localparam int TYPE_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int SEQ_W   = 32;
  localparam int THR_W   = 25;

  // header fields ahead of the tag on the input bus, and ahead of the tag on the output bus
  localparam int IN_FIXED_W  = PROTO_W + TYPE_W + CHAN_W + SEQ_W;
  localparam int OUT_FIXED_W = CHAN_W + SEQ_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_SEED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELIABLE_CHAN  = 2'd2;

  localparam logic [PROTO_W-1:0] PROTOCOL_ID   = 32'h434E_5431;
  localparam logic [31:0]        DEFAULT_SEED  = 32'h9E37_79B9;
  localparam logic [TYPE_W-1:0]  TYPE_DATA     = 8'd2;
  localparam logic [CHAN_W-1:0]  RELIABLE_RST  = 8'd1;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic enabled;
    logic drop;
  } loss_status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

[src/rorb_loss_gen.sv]
`timescale 1ns / 1ps

module rorb_loss_gen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rorb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rorb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               step,
  output rorb_pkg::loss_status_t             status
);
  import rorb_pkg::*;

  logic [THR_W-1:0] thr;
  logic [31:0]      gen;
  logic [31:0]      gen_next;

  assign gen_next       = xorshift32(gen);
  assign status.enabled = (thr != '0);
  assign status.drop    = ({1'b0, gen_next[31:8]} < thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
      gen <= DEFAULT_SEED;
    end else begin
      if (cfg_we && cfg_index == REG_LOSS_THRESHOLD) begin
        thr <= cfg_data[THR_W-1:0];
      end
      if (cfg_we && cfg_index == REG_LOSS_SEED) begin
        gen <= (cfg_data == '0) ? DEFAULT_SEED : cfg_data[31:0];
      end else if (step) begin
        gen <= gen_next;
      end
    end
  end

endmodule

[src/reliable_ordered_receiver.sv]
`timescale 1ns / 1ps

// Reliable ordered receiver. Each request carries one datagram header and a payload
// handle; results are acks (tuser 0) and delivered messages (tuser 1), tlast marking
// the final result of a request. The block takes one request at a time: protocol/loss
// check and classification, then for reliable data at or past the expected number one
// or more scans of the reorder buffer through a single sequence comparator, one slot
// a cycle. Buffering a future number costs up to one full scan; delivering the expected
// number costs one scan per buffered successor drained (ending at the hit) and a final
// full scan. Output back-pressure adds cycles wherever a result is waiting. Slot valid
// bits clear at reset, so there is no clearing pass.
module reliable_ordered_receiver #(
  parameter  int REORDER_DEPTH = rorb_pkg::REORDER_DEPTH_DEF,
  parameter  int TAG_BITS      = rorb_pkg::TAG_BITS_DEF,
  localparam int IN_W  = ((rorb_pkg::IN_FIXED_W + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((rorb_pkg::OUT_FIXED_W + TAG_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // protocol_word, packet_type, channel_code, sequence_req, payload_tag
  input  logic [IN_W-1:0]                 s_axis_tdata,
  // known_peer
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_channel, out_sequence, out_tag
  output logic [OUT_W-1:0]                m_axis_tdata,
  // result_kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [rorb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rorb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rorb_pkg::*;

  localparam int IDX_W = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
  localparam int CNT_W = $clog2(REORDER_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(REORDER_DEPTH);
  localparam int ENT_W = SEQ_W + TAG_BITS;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CHECK    = 3'd1;
  localparam logic [2:0] ST_CLASSIFY = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_HIT      = 3'd4;

  logic [2:0]          state;

  logic [PROTO_W-1:0]  proto_q;
  logic [TYPE_W-1:0]   type_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                known_q;

  logic [CHAN_W-1:0]   rel_chan;
  logic [SEQ_W-1:0]    expected;

  logic [REORDER_DEPTH-1:0] slot_valid;
  logic [ENT_W-1:0]         slot_mem [REORDER_DEPTH];
  logic [SEQ_W-1:0]         rd_seq;
  logic [TAG_BITS-1:0]      rd_tag;
  logic                     rd_v;

  logic [CNT_W-1:0]    issue_idx;
  logic [IDX_W-1:0]    cmp_idx;
  logic                cmp_vld;
  logic                drain_mode;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic [SEQ_W-1:0]    pend_seq;
  logic [TAG_BITS-1:0] pend_tag;

  logic [CHAN_W-1:0]   out_chan;
  logic [SEQ_W-1:0]    out_seq;
  logic [TAG_BITS-1:0] out_tag;

  loss_status_t        loss;
  logic                loss_step;
  logic                proto_ok;
  logic                data_ok;
  logic                out_free;
  logic [SEQ_W-1:0]    key;
  logic                hit;
  logic                scan_done;
  logic                mem_re;
  logic                mem_we;

  logic                emit;
  logic                emit_kind;
  logic [CHAN_W-1:0]   emit_chan;
  logic [SEQ_W-1:0]    emit_seq;
  logic [TAG_BITS-1:0] emit_tag;
  logic                emit_last;

  rorb_loss_gen u_loss (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (loss_step),
    .status    (loss)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign proto_ok      = (proto_q == PROTOCOL_ID);
  assign data_ok       = (type_q == TYPE_DATA) && known_q;
  assign loss_step     = (state == ST_CHECK) && proto_ok && loss.enabled;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign key           = drain_mode ? expected : seq_q;
  assign hit           = cmp_vld && rd_v && (rd_seq == key);
  assign scan_done     = !cmp_vld && (issue_idx == DEPTH_CNT);
  assign mem_re        = (state == ST_SCAN) && (issue_idx < DEPTH_CNT) && !hit;
  assign mem_we        = (state == ST_SCAN) && !drain_mode && scan_done && free_found;

  always_comb begin
    m_axis_tdata                     = '0;
    m_axis_tdata[CHAN_W-1:0]         = out_chan;
    m_axis_tdata[CHAN_W +: SEQ_W]    = out_seq;
    m_axis_tdata[OUT_FIXED_W +: TAG_BITS] = out_tag;
  end

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_DELIVER;
    emit_chan = rel_chan;
    emit_seq  = pend_seq;
    emit_tag  = pend_tag;
    emit_last = 1'b1;
    unique case (state)
      ST_CLASSIFY: begin
        if (data_ok) begin
          emit = out_free;
          if (chan_q != rel_chan) begin
            emit_chan = chan_q;
            emit_seq  = seq_q;
            emit_tag  = tag_q;
          end else begin
            emit_kind = KIND_ACK;
            emit_seq  = seq_q;
            emit_tag  = '0;
            emit_last = (seq_q != expected);
          end
        end
      end
      ST_SCAN: begin
        emit = drain_mode && scan_done && out_free;
      end
      ST_HIT: begin
        emit      = out_free;
        emit_last = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // slot store: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[free_idx] <= {tag_q, seq_q};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      {rd_tag, rd_seq} <= slot_mem[issue_idx[IDX_W-1:0]];
      rd_v             <= slot_valid[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      proto_q <= s_axis_tdata[PROTO_W-1:0];
      type_q  <= s_axis_tdata[PROTO_W +: TYPE_W];
      chan_q  <= s_axis_tdata[PROTO_W + TYPE_W +: CHAN_W];
      seq_q   <= s_axis_tdata[PROTO_W + TYPE_W + CHAN_W +: SEQ_W];
      tag_q   <= s_axis_tdata[IN_FIXED_W +: TAG_BITS];
      known_q <= s_axis_tuser;
    end
    if (emit) begin
      out_chan     <= emit_chan;
      out_seq      <= emit_seq;
      out_tag      <= emit_tag;
      m_axis_tuser <= emit_kind;
      m_axis_tlast <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_chan <= RELIABLE_RST;
    end else if (cfg_we && cfg_index == REG_RELIABLE_CHAN) begin
      rel_chan <= cfg_data[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      expected   <= SEQ_W'(1);
      slot_valid <= '0;
      issue_idx  <= '0;
      cmp_vld    <= 1'b0;
      drain_mode <= 1'b0;
      free_found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!proto_ok || (loss.enabled && loss.drop)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          issue_idx  <= '0;
          cmp_vld    <= 1'b0;
          free_found <= 1'b0;
          if (!data_ok) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            if (chan_q != rel_chan) begin
              state <= ST_IDLE;
            end else if (seq_q == expected) begin
              pend_seq   <= seq_q;
              pend_tag   <= tag_q;
              expected   <= expected + SEQ_W'(1);
              drain_mode <= 1'b1;
              state      <= ST_SCAN;
            end else if (seq_q > expected) begin
              drain_mode <= 1'b0;
              state      <= ST_SCAN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (mem_re) begin
            issue_idx <= issue_idx + CNT_W'(1);
            cmp_idx   <= issue_idx[IDX_W-1:0];
            cmp_vld   <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (hit) begin
            state <= drain_mode ? ST_HIT : ST_IDLE;
          end else if (cmp_vld && !rd_v && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end else if (scan_done) begin
            if (!drain_mode) begin
              if (free_found) begin
                slot_valid[free_idx] <= 1'b1;
              end
              state <= ST_IDLE;
            end else if (out_free) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_HIT: begin
          if (out_free) begin
            pend_seq            <= rd_seq;
            pend_tag            <= rd_tag;
            slot_valid[cmp_idx] <= 1'b0;
            expected            <= expected + SEQ_W'(1);
            issue_idx           <= '0;
            cmp_vld             <= 1'b0;
            state               <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rorb_checker.sv]
`timescale 1ns / 1ps

module rorb_checker #(
  parameter int TAG_BITS = rorb_pkg::TAG_BITS_DEF,
  parameter int OUT_W    = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);
  import rorb_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result presented after reset");

  // no new request taken while a run of results is still open
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready during an open result run");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready straight after a request");

  a_ack_no_tag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_ACK) |->
      (m_axis_tdata[OUT_FIXED_W +: TAG_BITS] == '0))
    else $error("ack carries a payload tag");

endmodule

bind reliable_ordered_receiver rorb_checker #(
  .TAG_BITS (TAG_BITS),
  .OUT_W    (OUT_W)
) u_rorb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
